/* design/cpms_pkg.sv */
// Package for the card presence and mount supervisor.
// Holds the status and register codes, the configuration, state, item and result
// types shared by the step logic and the top level. Depends on nothing.
package cpms_pkg;

    localparam int unsigned TimeW    = 32;
    localparam int unsigned HoldW    = 16;
    localparam int unsigned IntervW  = 24;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    typedef enum logic [1:0] {
        ST_OK               = 2'd0,
        ST_NOT_FOUND        = 2'd1,
        ST_INVALID_RESPONSE = 2'd2,
        ST_INVALID_STATE    = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DETECT_PRESENT  = 3'd0,
        CFG_INSERT_SETTLE   = 3'd1,
        CFG_REMOVE_DEBOUNCE = 3'd2,
        CFG_BLIND_PROBE     = 3'd3,
        CFG_RETRY_PRESENT   = 3'd4,
        CFG_RETRY_MIN       = 3'd5,
        CFG_RETRY_MAX       = 3'd6,
        CFG_MOUNT_POINT_SET = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_UNMOUNT = 1'b1
    } t_op;

    typedef struct packed {
        logic               detect_present;
        logic [HoldW-1:0]   insert_settle_ms;
        logic [HoldW-1:0]   remove_debounce_ms;
        logic [IntervW-1:0] blind_probe_ms;
        logic [IntervW-1:0] retry_present_ms;
        logic [IntervW-1:0] retry_min_ms;
        logic [IntervW-1:0] retry_max_ms;
        logic               mount_point_set;
    } t_cfg;

    typedef struct packed {
        logic               debounced_inserted;
        logic [TimeW-1:0]   stable_since_ms;
        logic [TimeW-1:0]   last_probe_ms;
        logic [IntervW-1:0] retry_interval_ms;
        logic               line_validated;
        logic               line_rejected;
        logic               mounted;
        logic               registered;
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [TimeW-1:0] now_ms;
        logic             detect_level;
        logic             lock_granted;
        logic             mount_ok;
        logic             probe_ok;
    } t_item;

    // Declared high field first so that status lands in the lowest bits.
    typedef struct packed {
        logic    detect_usable;
        logic    probe_attempted;
        logic    mount_attempted;
        logic    card_inserted;
        logic    mounted;
        t_status status;
    } t_result;

endpackage

/* design/card_presence_mount_supervisor_top.sv */
// Top level of the card presence and mount supervisor.
// Holds the configuration registers, the input word register, the supervisor
// state and the result register; instantiates cpms_step. Depends on cpms_pkg.
//
// Usage:
//   Configuration: write register i_cfg_index with i_cfg_data on the cfg channel
//   (o_cfg_ready is always high); write only while the block is idle.
//   Input words on the s channel: tdata holds now_ms, detect_level,
//   lock_granted, mount_ok, probe_ok; tuser holds op (0 update, 1 unmount).
//   Each input word yields exactly one result word on the m channel: status,
//   mounted, card_inserted, mount_attempted, probe_attempted, detect_usable.
//   Path: the word passes through the input register, then the single-pass step into
//   the result register. Throughput: one word per cycle while the m side does
//   not stall; the state update happens as the word moves into the result
//   register, so the next word already sees it.
//   Stall: when the m side holds tready low, the result register holds, and the
//   input register fills; o_s_tready drops only when both are full.
//   Reset (i_rst_n low, synchronous): clear the configuration, all supervisor
//   state and both valid flags; no clearing pass is needed.
module card_presence_mount_supervisor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] now_ms, [32] detect_level, [33] lock_granted, [34] mount_ok,
    // [35] probe_ok, [39:36] zero
    input  logic [cpms_pkg::InDataW-1:0]    i_s_tdata,
    // [0] op
    input  logic                            i_s_tuser,
    // Result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [2] mounted, [3] card_inserted, [4] mount_attempted,
    // [5] probe_attempted, [6] detect_usable, [7] zero
    output logic [cpms_pkg::OutDataW-1:0]   o_m_tdata,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cpms_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [cpms_pkg::CfgDataW-1:0]   i_cfg_data
);

    cpms_pkg::t_cfg    r_cfg;
    cpms_pkg::t_state  r_state;
    cpms_pkg::t_state  n_state;
    cpms_pkg::t_item   r_in;
    logic              r_in_valid;
    cpms_pkg::t_result r_out;
    cpms_pkg::t_result n_out;
    logic              r_out_valid;
    logic              w_adv;

    // Move the input word on when the result register is free or being drained.
    assign w_adv       = ~r_out_valid | i_m_tready;
    assign o_s_tready  = ~r_in_valid | w_adv;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cpms_pkg::CFG_DETECT_PRESENT:  r_cfg.detect_present     <= i_cfg_data[0];
                cpms_pkg::CFG_INSERT_SETTLE:   r_cfg.insert_settle_ms   <= i_cfg_data[15:0];
                cpms_pkg::CFG_REMOVE_DEBOUNCE: r_cfg.remove_debounce_ms <= i_cfg_data[15:0];
                cpms_pkg::CFG_BLIND_PROBE:     r_cfg.blind_probe_ms     <= i_cfg_data;
                cpms_pkg::CFG_RETRY_PRESENT:   r_cfg.retry_present_ms   <= i_cfg_data;
                cpms_pkg::CFG_RETRY_MIN:       r_cfg.retry_min_ms       <= i_cfg_data;
                cpms_pkg::CFG_RETRY_MAX:       r_cfg.retry_max_ms       <= i_cfg_data;
                cpms_pkg::CFG_MOUNT_POINT_SET: r_cfg.mount_point_set    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.op           <= cpms_pkg::t_op'(i_s_tuser);
            r_in.now_ms       <= i_s_tdata[31:0];
            r_in.detect_level <= i_s_tdata[32];
            r_in.lock_granted <= i_s_tdata[33];
            r_in.mount_ok     <= i_s_tdata[34];
            r_in.probe_ok     <= i_s_tdata[35];
        end
    end

    cpms_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Commit state and result together as the word moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

    // A detect line is never both trusted and rejected.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.line_validated && r_state.line_rejected))
        else $error("line validated and rejected at once");

    // A live mount is always a registered one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.mounted && !r_state.registered))
        else $error("mounted without registration");

    // A failed mount attempt reports not found and leaves nothing mounted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mount_attempted && !r_out.probe_attempted)
        |-> (r_out.status == cpms_pkg::ST_NOT_FOUND && !r_out.mounted))
        else $error("failed mount result inconsistent");

    // A mount attempt never reports invalid state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mount_attempted)
        |-> (r_out.status != cpms_pkg::ST_INVALID_STATE))
        else $error("mount attempted with invalid state");

    // A word leaving the input register shows up as a result next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> r_out_valid)
        else $error("input word lost");

endmodule

/* design/cpms_step.sv */
// Combinational step of the card presence and mount supervisor.
// Maps the current state, configuration and one item to the next state and one
// result. Depends on cpms_pkg.
module cpms_step (
    input  cpms_pkg::t_cfg    i_cfg,
    input  cpms_pkg::t_state  i_state,
    input  cpms_pkg::t_item   i_item,
    output cpms_pkg::t_state  o_state,
    output cpms_pkg::t_result o_result
);

    logic                              usable;
    logic                              inserted;
    logic                              insert_edge;
    logic [cpms_pkg::HoldW-1:0]        hold;
    logic [cpms_pkg::TimeW-1:0]        since_stable;
    logic [cpms_pkg::TimeW-1:0]        since_probe;
    logic [cpms_pkg::IntervW-1:0]      retry_cur;
    logic [cpms_pkg::IntervW-1:0]      wait_ms;
    logic [cpms_pkg::IntervW:0]        doubled;
    logic [cpms_pkg::IntervW-1:0]      backoff;
    logic                              mount_tried;
    logic                              probe_tried;
    cpms_pkg::t_status                 status;
    cpms_pkg::t_state                  ns;

    assign usable       = i_cfg.detect_present & i_state.line_validated & ~i_state.line_rejected;
    assign since_stable = i_item.now_ms - i_state.stable_since_ms;
    assign since_probe  = i_item.now_ms - i_state.last_probe_ms;
    assign hold         = i_item.detect_level ? i_cfg.insert_settle_ms : i_cfg.remove_debounce_ms;

    always_comb begin
        ns          = i_state;
        mount_tried = 1'b0;
        probe_tried = 1'b0;
        status      = cpms_pkg::ST_OK;
        inserted    = 1'b1;
        insert_edge = 1'b0;
        retry_cur   = i_state.retry_interval_ms;
        wait_ms     = '0;
        doubled     = '0;
        backoff     = '0;

        if (i_item.op == cpms_pkg::OP_UNMOUNT) begin
            ns.mounted    = 1'b0;
            ns.registered = 1'b0;
        end else begin
            // Debounce the detect line; without one, take the card as present.
            if (i_cfg.detect_present) begin
                if (i_item.detect_level != i_state.debounced_inserted) begin
                    if (since_stable >= {{(cpms_pkg::TimeW-cpms_pkg::HoldW){1'b0}}, hold}) begin
                        ns.debounced_inserted = i_item.detect_level;
                        ns.stable_since_ms    = i_item.now_ms;
                    end
                end else begin
                    ns.stable_since_ms = i_item.now_ms;
                end
                inserted = ns.debounced_inserted;
            end
            insert_edge = i_cfg.detect_present & inserted & ~i_state.debounced_inserted;

            if (!i_item.lock_granted) begin
                status = i_state.mounted ? cpms_pkg::ST_OK : cpms_pkg::ST_NOT_FOUND;
            end else if (i_state.mounted) begin
                if (usable && !inserted) begin
                    ns.mounted = 1'b0;
                    status     = cpms_pkg::ST_NOT_FOUND;
                end else if (!usable && since_probe <
                             {{(cpms_pkg::TimeW-cpms_pkg::IntervW){1'b0}}, i_cfg.blind_probe_ms}) begin
                    status = cpms_pkg::ST_OK;
                end else begin
                    ns.last_probe_ms = i_item.now_ms;
                    probe_tried      = 1'b1;
                    if (!i_item.probe_ok) begin
                        if (usable) begin
                            ns.line_validated = 1'b0;
                            ns.line_rejected  = 1'b1;
                        end
                        ns.mounted = 1'b0;
                        status     = cpms_pkg::ST_INVALID_RESPONSE;
                    end
                end
            end else if (i_state.registered) begin
                status = cpms_pkg::ST_NOT_FOUND;
            end else if (!i_cfg.mount_point_set) begin
                status = cpms_pkg::ST_INVALID_STATE;
            end else if (usable && !inserted) begin
                status = cpms_pkg::ST_NOT_FOUND;
            end else begin
                // Restart backoff on a real insert edge.
                if (insert_edge) begin
                    retry_cur = '0;
                end
                ns.retry_interval_ms = retry_cur;
                wait_ms = (usable && inserted) ? i_cfg.retry_present_ms : retry_cur;
                if (since_probe < {{(cpms_pkg::TimeW-cpms_pkg::IntervW){1'b0}}, wait_ms}) begin
                    status = cpms_pkg::ST_NOT_FOUND;
                end else begin
                    ns.last_probe_ms = i_item.now_ms;
                    mount_tried      = 1'b1;
                    if (!i_item.mount_ok) begin
                        doubled = {retry_cur, 1'b0};
                        if (retry_cur < i_cfg.retry_min_ms) begin
                            backoff = i_cfg.retry_min_ms;
                        end else if (doubled < {1'b0, i_cfg.retry_max_ms}) begin
                            backoff = doubled[cpms_pkg::IntervW-1:0];
                        end else begin
                            backoff = i_cfg.retry_max_ms;
                        end
                        ns.retry_interval_ms = backoff;
                        status               = cpms_pkg::ST_NOT_FOUND;
                    end else begin
                        ns.mounted           = 1'b1;
                        ns.registered        = 1'b1;
                        ns.retry_interval_ms = i_cfg.retry_min_ms;
                        // First good mount settles whether the detect line is trusted.
                        if (i_cfg.detect_present && !i_state.line_validated &&
                            !i_state.line_rejected) begin
                            ns.debounced_inserted = i_item.detect_level;
                            ns.line_validated     = i_item.detect_level;
                            ns.line_rejected      = ~i_item.detect_level;
                            ns.stable_since_ms    = i_item.now_ms;
                        end
                        probe_tried = 1'b1;
                        status = i_item.probe_ok ? cpms_pkg::ST_OK : cpms_pkg::ST_INVALID_RESPONSE;
                    end
                end
            end
        end
    end

    assign o_state                  = ns;
    assign o_result.status          = status;
    assign o_result.mounted         = ns.mounted;
    assign o_result.card_inserted   = ~i_cfg.detect_present | ns.debounced_inserted;
    assign o_result.mount_attempted = mount_tried;
    assign o_result.probe_attempted = probe_tried;
    assign o_result.detect_usable   = i_cfg.detect_present & ns.line_validated & ~ns.line_rejected;

endmodule
